// ----- sv/tcp_pkg.sv -----
// Shared constants, codes and control structs of the token chunk planner.
package tcp_pkg;

  localparam int unsigned NUM_VARIANTS_DEF = 4;
  localparam int unsigned MAX_BATCH_DEF    = 32;
  localparam int unsigned MAX_SEQS_DEF     = 1024;

  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LIMIT_W    = 6;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned RES_W      = $clog2(RESULT_CAP);
  // padding bound is four times the real tokens
  localparam int unsigned PAD_SHIFT  = 2;
  localparam int unsigned ONE_TOKEN  = 1;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_ONE = 2'd1,
    STAT_OVF    = 2'd2
  } status_e;

  typedef enum logic {
    CMD_NEXT = 1'b0,
    CMD_END  = 1'b1
  } command_e;

  typedef struct packed {
    logic capture_in;
    logic load_cfg;
    logic seq_take;
    logic seq_clear;
    logic flush_init;
    logic fit_batch;
    logic emit_batch;
    logic batch_clear;
    logic push;
    logic cut_init;
    logic fit_cut;
    logic emit_cut;
    logic emit_err;
  } tcp_cmd_t;

  typedef struct packed {
    logic has_one;
    logic cmd_end;
    logic len_zero;
    logic len_one;
    logic batch_empty;
    logic batch_full;
    logic slot_free;
    logic batch_last;
    logic cut_last;
  } tcp_stat_t;

endpackage

// ----- sv/tcp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tcp_ctrl.sv -----
// Sequencing state machine of the token chunk planner.
module tcp_ctrl import tcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tcp_stat_t stat_i,
  output tcp_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PREP     = 9'b000000010,
    S_DECIDE   = 9'b000000100,
    S_ERR      = 9'b000001000,
    S_FL_RD    = 9'b000010000,
    S_FL_EMIT  = 9'b000100000,
    S_PUSH     = 9'b001000000,
    S_CUT_FIT  = 9'b010000000,
    S_CUT_EMIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   push_after_q, push_after_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    push_after_d = push_after_q;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture_in = 1'b1;
          state_d          = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.load_cfg = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat_i.has_one) begin
          state_d = S_ERR;
        end else if (stat_i.cmd_end) begin
          cmd_o.seq_clear  = 1'b1;
          cmd_o.flush_init = 1'b1;
          push_after_d     = 1'b0;
          state_d          = stat_i.batch_empty ? S_IDLE : S_FL_RD;
        end else begin
          cmd_o.seq_take = 1'b1;
          if (stat_i.len_zero) begin
            state_d = S_IDLE;
          end else if (stat_i.len_one) begin
            if (stat_i.batch_full) begin
              cmd_o.flush_init = 1'b1;
              push_after_d     = 1'b1;
              state_d          = S_FL_RD;
            end else begin
              state_d = S_PUSH;
            end
          end else begin
            cmd_o.cut_init = 1'b1;
            state_d        = S_CUT_FIT;
          end
        end
      end
      S_ERR: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FL_RD: begin
        cmd_o.fit_batch = 1'b1;
        state_d         = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_batch = 1'b1;
          if (stat_i.batch_last) begin
            cmd_o.batch_clear = 1'b1;
            state_d           = push_after_q ? S_PUSH : S_IDLE;
          end else begin
            state_d = S_FL_RD;
          end
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_IDLE;
      end
      S_CUT_FIT: begin
        cmd_o.fit_cut = 1'b1;
        state_d       = S_CUT_EMIT;
      end
      S_CUT_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_cut = 1'b1;
          state_d        = stat_i.cut_last ? S_IDLE : S_CUT_FIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      push_after_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      push_after_q <= push_after_d;
    end
  end

endmodule

// ----- sv/tcp_datapath.sv -----
// Datapath of the token chunk planner: registers, size fitting, batch store, output stage.
module tcp_datapath import tcp_pkg::*; #(
  parameter int unsigned NUM_VARIANTS = NUM_VARIANTS_DEF,
  parameter int unsigned MAX_BATCH    = MAX_BATCH_DEF,
  parameter int unsigned MAX_SEQS     = MAX_SEQS_DEF,
  localparam int unsigned CfgIdxW = $clog2(NUM_VARIANTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_data_i,
  input  logic               command_i,
  input  logic [LEN_W-1:0]   seq_length_i,
  input  tcp_cmd_t           cmd_i,
  output tcp_stat_t          stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SIZE_W-1:0]  chunk_size_o,
  output logic [IDX_W-1:0]   seq_index_o,
  output logic [LEN_W-1:0]   token_offset_o,
  output logic [SIZE_W-1:0]  piece_tokens_o,
  output logic               chunk_start_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int unsigned SeqW = $clog2(MAX_SEQS);
  localparam int unsigned CntW = $clog2(MAX_BATCH + 1);
  localparam int unsigned AW   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  // configuration
  logic [SIZE_W-1:0]  variant_q [NUM_VARIANTS];
  logic [LIMIT_W-1:0] batch_limit_q;

  // persistent state
  logic [SeqW-1:0] seq_cnt_q, seq_cnt_d;
  logic [CntW-1:0] batch_cnt_q;

  // per-item registers
  logic              cmd_q;
  logic [LEN_W-1:0]  len_q;
  logic              has_one_q, has_one_d;
  logic [SIZE_W-1:0] largest_q, largest_d;
  logic [SIZE_W-1:0] small_q, small_d;
  logic [CntW-1:0]   lim_q, lim_d;
  logic [SIZE_W-1:0] lim_a;
  logic [SeqW-1:0]   seq_q;
  logic [LEN_W-1:0]  rem_q, off_q;
  logic [RES_W-1:0]  res_cnt_q;
  logic [CntW-1:0]   flush_idx_q;
  logic [SIZE_W-1:0] fitup_q, fitup_d;
  logic [SIZE_W-1:0] fitdn_q, fitdn_d;
  logic [SIZE_W-1:0] fit_x;
  logic              ge_q, ge_d;
  logic [SIZE_W:0]   bound_q, bound_d;

  // output stage
  logic              out_valid_q;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  sidx_q, sidx_d;
  logic [LEN_W-1:0]  offo_q, offo_d;
  logic [SIZE_W-1:0] tok_q, tok_d;
  logic              start_q, start_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;

  // cut step
  logic              pad_ok;
  logic [LEN_W-1:0]  n_sel;
  logic [SIZE_W-1:0] dim_sel;
  logic [LEN_W-1:0]  rem_next;
  logic              cut_done, cut_over;

  logic              ram_we;
  logic [SeqW-1:0]   ram_rdata;
  logic              emit;
  logic [IDX_W+SeqW-1:0] seq_ext_cnt, seq_ext_q, seq_ext_ram;

  // variant summary: one-token presence, largest, smallest multi-token size
  always_comb begin
    has_one_d = 1'b0;
    largest_d = '0;
    small_d   = SIZE_W'(ONE_TOKEN);
    for (int i = 0; i < NUM_VARIANTS; i++) begin
      if (variant_q[i] == SIZE_W'(ONE_TOKEN)) has_one_d = 1'b1;
      if (variant_q[i] > largest_d) largest_d = variant_q[i];
      if (variant_q[i] > SIZE_W'(ONE_TOKEN) &&
          (small_d == SIZE_W'(ONE_TOKEN) || variant_q[i] < small_d)) begin
        small_d = variant_q[i];
      end
    end
    lim_a = (batch_limit_q == '0) ? SIZE_W'(ONE_TOKEN) : SIZE_W'(batch_limit_q);
    if (lim_a > SIZE_W'(MAX_BATCH)) lim_a = SIZE_W'(MAX_BATCH);
    if (lim_a > largest_d) lim_a = largest_d;
    lim_d = lim_a[CntW-1:0];
  end

  // fit unit: smallest size holding x, largest size not above x
  always_comb begin
    fit_x   = cmd_i.fit_batch ? SIZE_W'(batch_cnt_q) : SIZE_W'(rem_q);
    fitup_d = largest_q;
    fitdn_d = '0;
    for (int i = 0; i < NUM_VARIANTS; i++) begin
      if (variant_q[i] >= fit_x && variant_q[i] < fitup_d) fitup_d = variant_q[i];
      if (variant_q[i] <= fit_x && variant_q[i] > fitdn_d) fitdn_d = variant_q[i];
    end
    ge_d    = {1'b0, rem_q} >= largest_q;
    bound_d = (SIZE_W + 1)'(rem_q) << PAD_SHIFT;
    if (bound_d < {1'b0, small_q}) bound_d = {1'b0, small_q};
  end

  // choose the piece of the current cut step
  always_comb begin
    pad_ok = {1'b0, fitup_q} <= bound_q;
    if (ge_q) begin
      n_sel   = largest_q[LEN_W-1:0];
      dim_sel = largest_q;
    end else if (pad_ok) begin
      n_sel   = rem_q;
      dim_sel = fitup_q;
    end else begin
      n_sel   = fitdn_q[LEN_W-1:0];
      dim_sel = fitdn_q;
    end
    rem_next = rem_q - n_sel;
    cut_done = (rem_next == '0);
    cut_over = (res_cnt_q == RES_W'(RESULT_CAP - 1)) && !cut_done;
  end

  assign seq_cnt_d = (seq_cnt_q == SeqW'(MAX_SEQS - 1)) ? '0 : seq_cnt_q + 1'b1;

  assign seq_ext_cnt = {{IDX_W{1'b0}}, seq_cnt_q};
  assign seq_ext_q   = {{IDX_W{1'b0}}, seq_q};
  assign seq_ext_ram = {{IDX_W{1'b0}}, ram_rdata};

  // output payload selection
  always_comb begin
    size_d   = '0;
    sidx_d   = seq_ext_cnt[IDX_W-1:0];
    offo_d   = '0;
    tok_d    = '0;
    start_d  = 1'b0;
    status_d = STAT_NO_ONE;
    last_d   = 1'b1;
    if (cmd_i.emit_batch) begin
      size_d   = fitup_q;
      sidx_d   = seq_ext_ram[IDX_W-1:0];
      tok_d    = SIZE_W'(ONE_TOKEN);
      start_d  = (flush_idx_q == '0);
      status_d = STAT_OK;
      last_d   = stat_o.batch_last;
    end else if (cmd_i.emit_cut) begin
      size_d   = dim_sel;
      sidx_d   = seq_ext_q[IDX_W-1:0];
      offo_d   = off_q;
      tok_d    = SIZE_W'(n_sel);
      start_d  = 1'b1;
      status_d = cut_over ? STAT_OVF : STAT_OK;
      last_d   = cut_done || cut_over;
    end
  end

  assign emit   = cmd_i.emit_err || cmd_i.emit_batch || cmd_i.emit_cut;
  assign ram_we = cmd_i.push && (batch_cnt_q < CntW'(MAX_BATCH));

  tcp_ram #(
    .WIDTH (SeqW),
    .DEPTH (MAX_BATCH)
  ) u_batch_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (batch_cnt_q[AW-1:0]),
    .wdata_i (seq_q),
    .raddr_i (flush_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VARIANTS; i++) begin
        variant_q[i] <= (i == 0) ? SIZE_W'(ONE_TOKEN) : '0;
      end
      batch_limit_q <= LIMIT_W'(1);
      seq_cnt_q     <= '0;
      batch_cnt_q   <= '0;
      flush_idx_q   <= '0;
      res_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        for (int i = 0; i < NUM_VARIANTS; i++) begin
          if (cfg_idx_i == CfgIdxW'(i)) variant_q[i] <= cfg_data_i;
        end
        if (cfg_idx_i == CfgIdxW'(NUM_VARIANTS)) batch_limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
      if (cmd_i.seq_clear) begin
        seq_cnt_q <= '0;
      end else if (cmd_i.seq_take) begin
        seq_cnt_q <= seq_cnt_d;
      end
      if (cmd_i.batch_clear) begin
        batch_cnt_q <= '0;
      end else if (ram_we) begin
        batch_cnt_q <= batch_cnt_q + 1'b1;
      end
      if (cmd_i.flush_init) begin
        flush_idx_q <= '0;
      end else if (cmd_i.emit_batch) begin
        flush_idx_q <= flush_idx_q + 1'b1;
      end
      if (cmd_i.cut_init) begin
        res_cnt_q <= '0;
      end else if (cmd_i.emit_cut) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      cmd_q <= command_i;
      len_q <= seq_length_i;
    end
    if (cmd_i.load_cfg) begin
      has_one_q <= has_one_d;
      largest_q <= largest_d;
      small_q   <= small_d;
      lim_q     <= lim_d;
    end
    if (cmd_i.seq_take) seq_q <= seq_cnt_q;
    if (cmd_i.cut_init) begin
      rem_q <= len_q;
      off_q <= '0;
    end else if (cmd_i.emit_cut) begin
      rem_q <= rem_next;
      off_q <= off_q + n_sel;
    end
    if (cmd_i.fit_cut || cmd_i.fit_batch) fitup_q <= fitup_d;
    if (cmd_i.fit_cut) begin
      fitdn_q <= fitdn_d;
      ge_q    <= ge_d;
      bound_q <= bound_d;
    end
    if (emit) begin
      size_q   <= size_d;
      sidx_q   <= sidx_d;
      offo_q   <= offo_d;
      tok_q    <= tok_d;
      start_q  <= start_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  always_comb begin
    stat_o.has_one     = has_one_q;
    stat_o.cmd_end     = (cmd_q == CMD_END);
    stat_o.len_zero    = (len_q == '0);
    stat_o.len_one     = (len_q == LEN_W'(ONE_TOKEN));
    stat_o.batch_empty = (batch_cnt_q == '0);
    stat_o.batch_full  = (batch_cnt_q >= lim_q);
    stat_o.slot_free   = !out_valid_q || out_ready_i;
    stat_o.batch_last  = (CntW'(flush_idx_q + 1'b1) == batch_cnt_q);
    stat_o.cut_last    = cut_done || cut_over;
  end

  assign out_valid_o    = out_valid_q;
  assign chunk_size_o   = size_q;
  assign seq_index_o    = sidx_q;
  assign token_offset_o = offo_q;
  assign piece_tokens_o = tok_q;
  assign chunk_start_o  = start_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

// ----- sv/token_chunk_planner.sv -----
// Top level of the token chunk planner: state machine plus datapath.
//
// Usage: each input request carries a command and a subsequence length.
// A next-subsequence request takes the next sequence number; lengths of one
// are gathered into a batch (up to the batch limit), longer ones are cut into
// chunks sized from the configured variant sizes. An end request flushes the
// batch and restarts numbering. Results leave one piece per output request,
// with last set on the final piece of the input request.
// Timing: one request at a time. Decode steps through capture, summarizing
// the variant table and deciding; each result then takes the shared fit unit
// or the batch store read, then the output register load. An error result
// skips the fit step. A zero length or an end with an empty batch returns to
// idle after the decision; parking a single token takes a further push step,
// after any batch flush it forces.
// The output register decouples the sides: the next request is taken while
// the last result still waits. When the receiver stalls, the planner holds
// its current piece until the output register frees up.
// Reset: variant a = 1, others 0, batch limit 1, numbering and batch empty.
// The user must make configuration writes only while idle; the block does not enforce it.
module token_chunk_planner import tcp_pkg::*; #(
  parameter int unsigned NUM_VARIANTS = NUM_VARIANTS_DEF,
  parameter int unsigned MAX_BATCH    = MAX_BATCH_DEF,
  parameter int unsigned MAX_SEQS     = MAX_SEQS_DEF,
  localparam int unsigned CfgIdxW = $clog2(NUM_VARIANTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [LEN_W-1:0]   seq_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SIZE_W-1:0]  chunk_size_o,
  output logic [IDX_W-1:0]   seq_index_o,
  output logic [LEN_W-1:0]   token_offset_o,
  output logic [SIZE_W-1:0]  piece_tokens_o,
  output logic               chunk_start_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  tcp_cmd_t  cmd;
  tcp_stat_t stat;

  // sequencing: one request at a time, one step per state
  tcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // registers, fit unit, batch store and the output register
  tcp_datapath #(
    .NUM_VARIANTS (NUM_VARIANTS),
    .MAX_BATCH    (MAX_BATCH),
    .MAX_SEQS     (MAX_SEQS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .seq_length_i   (seq_length_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chunk_size_o   (chunk_size_o),
    .seq_index_o    (seq_index_o),
    .token_offset_o (token_offset_o),
    .piece_tokens_o (piece_tokens_o),
    .chunk_start_o  (chunk_start_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ----- sv/tcp_checker.sv -----
// Port-level checks for the token chunk planner, bound to the top level.
module tcp_checker import tcp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [SIZE_W-1:0] chunk_size_o,
  input logic [IDX_W-1:0]  seq_index_o,
  input logic [LEN_W-1:0]  token_offset_o,
  input logic [SIZE_W-1:0] piece_tokens_o,
  input logic              chunk_start_o,
  input logic [1:0]        status_o,
  input logic              last_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chunk_size_o) &&
      $stable(seq_index_o) && $stable(token_offset_o) && $stable(piece_tokens_o) &&
      $stable(chunk_start_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // error result stands alone and carries no chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_NO_ONE |-> last_o && chunk_size_o == '0 &&
      piece_tokens_o == '0 && !chunk_start_o)
    else $error("malformed error result");

  // overflow ends the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OVF |-> last_o && chunk_start_o)
    else $error("overflow result not final");

  // a piece always fits in its chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_NO_ONE |->
      piece_tokens_o != '0 && piece_tokens_o <= chunk_size_o)
    else $error("piece larger than chunk");

endmodule

bind token_chunk_planner tcp_checker u_tcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .chunk_size_o   (chunk_size_o),
  .seq_index_o    (seq_index_o),
  .token_offset_o (token_offset_o),
  .piece_tokens_o (piece_tokens_o),
  .chunk_start_o  (chunk_start_o),
  .status_o       (status_o),
  .last_o         (last_o)
);

// ----- test/chunk_plan_checker.sv -----
// Checker for the token chunk planner: predicts pieces per request and compares them.
`timescale 1ns / 1ps

module chunk_plan_checker import tcp_pkg::*; #(
  parameter int unsigned CFG_IDX_W = $clog2(NUM_VARIANTS_DEF + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 command_i,
  input  logic [LEN_W-1:0]     seq_length_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SIZE_W-1:0]    chunk_size_i,
  input  logic [IDX_W-1:0]     seq_index_i,
  input  logic [LEN_W-1:0]     token_offset_i,
  input  logic [SIZE_W-1:0]    piece_tokens_i,
  input  logic                 chunk_start_i,
  input  logic [1:0]           status_i,
  input  logic                 last_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          pieces_o
);

  localparam int unsigned REG_BATCH_LIMIT = NUM_VARIANTS_DEF;

  typedef struct packed {
    logic [SIZE_W-1:0] chunk_size;
    logic [IDX_W-1:0]  seq_index;
    logic [LEN_W-1:0]  token_offset;
    logic [SIZE_W-1:0] piece_tokens;
    logic              chunk_start;
    status_e           status;
    logic              last;
  } piece_t;

  // mirrored registers and planner state
  logic [SIZE_W-1:0]  variant_q [NUM_VARIANTS_DEF];
  logic [LIMIT_W-1:0] batch_limit_q;
  int unsigned        seq_ctr;
  int unsigned        batch_cnt;
  int unsigned        batch_seq [MAX_BATCH_DEF];

  // sorted, deduplicated nonzero sizes of the current request
  int unsigned sizes [NUM_VARIANTS_DEF];
  int unsigned num_sizes;

  piece_t      plan_q[$];
  piece_t      expected_pieces[$];
  int unsigned mismatches = 0;
  int unsigned pieces_checked = 0;

  assign fail_count_o = mismatches;
  assign pieces_o     = pieces_checked;

  function automatic void refresh_sizes();
    int unsigned v;
    bit          dup;
    int          j;
    num_sizes = 0;
    for (int i = 0; i < NUM_VARIANTS_DEF; i++) begin
      v = variant_q[i];
      dup = 1'b0;
      for (int m = 0; m < num_sizes; m++) begin
        if (sizes[m] == v) dup = 1'b1;
      end
      if (v != 0 && !dup) begin
        j = num_sizes;
        while (j > 0 && sizes[j-1] > v) begin
          sizes[j] = sizes[j-1];
          j--;
        end
        sizes[j] = v;
        num_sizes++;
      end
    end
  endfunction

  function automatic int unsigned fit_up(int unsigned n);
    for (int i = 0; i < num_sizes; i++) begin
      if (sizes[i] >= n) return sizes[i];
    end
    return sizes[num_sizes-1];
  endfunction

  function automatic int unsigned fit_down(int unsigned n);
    int unsigned best;
    best = sizes[0];
    for (int i = 0; i < num_sizes; i++) begin
      if (sizes[i] <= n) best = sizes[i];
    end
    return best;
  endfunction

  function automatic void add_piece(int unsigned size, int unsigned seq, int unsigned off,
                                    int unsigned tok, bit start, status_e st);
    piece_t p;
    p.chunk_size   = SIZE_W'(size);
    p.seq_index    = IDX_W'(seq);
    p.token_offset = LEN_W'(off);
    p.piece_tokens = SIZE_W'(tok);
    p.chunk_start  = start;
    p.status       = st;
    p.last         = 1'b0;
    plan_q.insert(plan_q.size(), p);
  endfunction

  function automatic void flush_batch();
    int unsigned dim;
    if (batch_cnt == 0) return;
    dim = fit_up(batch_cnt);
    for (int unsigned i = 0; i < batch_cnt; i++) begin
      add_piece(dim, batch_seq[i], 0, 1, i == 0, STAT_OK);
    end
    batch_cnt = 0;
  endfunction

  // Work out the pieces one accepted request causes and queue them.
  function automatic void plan_request(command_e cmd, int unsigned len);
    int unsigned largest, small_multi, seq, lim, off, rem, n, dim, padded, bound;
    piece_t      p;
    refresh_sizes();
    plan_q.delete();
    if (num_sizes == 0 || sizes[0] != ONE_TOKEN) begin
      add_piece(0, seq_ctr, 0, 0, 1'b0, STAT_NO_ONE);
    end else begin
      largest     = sizes[num_sizes-1];
      small_multi = num_sizes > 1 ? sizes[1] : sizes[0];
      if (cmd == CMD_END) begin
        flush_batch();
        seq_ctr = 0;
      end else begin
        seq     = seq_ctr;
        seq_ctr = (seq_ctr + 1) % MAX_SEQS_DEF;
        if (len == ONE_TOKEN) begin
          lim = batch_limit_q == 0 ? 1 : batch_limit_q;
          if (lim > MAX_BATCH_DEF) lim = MAX_BATCH_DEF;
          if (lim > largest) lim = largest;
          if (batch_cnt >= lim) flush_batch();
          if (batch_cnt < MAX_BATCH_DEF) begin
            batch_seq[batch_cnt] = seq;
            batch_cnt++;
          end
        end else begin
          off = 0;
          while (off < len) begin
            if (plan_q.size() == RESULT_CAP) begin
              // cut off: flag the last kept piece
              p = plan_q[plan_q.size()-1];
              p.status = STAT_OVF;
              plan_q[plan_q.size()-1] = p;
              break;
            end
            rem = len - off;
            if (rem >= largest) begin
              n   = largest;
              dim = largest;
            end else begin
              padded = fit_up(rem);
              bound  = rem << PAD_SHIFT;
              if (bound < small_multi) bound = small_multi;
              if (padded <= bound) begin
                n   = rem;
                dim = padded;
              end else begin
                n   = fit_down(rem);
                dim = n;
              end
            end
            add_piece(dim, seq, off, n, 1'b1, STAT_OK);
            off += n;
          end
        end
      end
    end
    if (plan_q.size() > 0) begin
      p = plan_q[plan_q.size()-1];
      p.last = 1'b1;
      plan_q[plan_q.size()-1] = p;
    end
    foreach (plan_q[i]) expected_pieces.insert(expected_pieces.size(), plan_q[i]);
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  task automatic check_piece();
    piece_t exp_p;
    if (expected_pieces.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected piece, expected none, actual seq %0d offset %0d",
               $time, seq_index_i, token_offset_i);
      return;
    end
    exp_p = expected_pieces.pop_front();
    pieces_checked++;
    check_field("chunk_size", exp_p.chunk_size, chunk_size_i);
    check_field("seq_index", exp_p.seq_index, seq_index_i);
    check_field("token_offset", exp_p.token_offset, token_offset_i);
    check_field("piece_tokens", exp_p.piece_tokens, piece_tokens_i);
    check_field("chunk_start", exp_p.chunk_start, chunk_start_i);
    check_field("status", exp_p.status, status_i);
    check_field("last", exp_p.last, last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VARIANTS_DEF; i++) variant_q[i] = '0;
      variant_q[0]  = SIZE_W'(ONE_TOKEN);
      batch_limit_q = LIMIT_W'(1);
      seq_ctr       = 0;
      batch_cnt     = 0;
      expected_pieces.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < NUM_VARIANTS_DEF) variant_q[cfg_idx_i] = cfg_data_i;
        else if (cfg_idx_i == REG_BATCH_LIMIT) batch_limit_q = cfg_data_i[LIMIT_W-1:0];
      end
      if (in_valid_i && in_ready_i) plan_request(command_e'(command_i), seq_length_i);
      if (out_valid_i && out_ready_i) check_piece();
      pending_o <= expected_pieces.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the token chunk planner: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb;
  import tcp_pkg::*;

  localparam int unsigned CFG_IDX_W     = $clog2(NUM_VARIANTS_DEF + 1);
  localparam time         CLK_PERIOD    = 12ns;
  localparam int unsigned STALL_MAX     = 12;   // longest per-request gap on either side
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 12;   // covers a resultless request still in flight
  localparam int unsigned IDLE_LIMIT    = 3000; // cycles without any handshake or register write
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 36;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 command_i;
  logic [LEN_W-1:0]     seq_length_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SIZE_W-1:0]    chunk_size_o;
  logic [IDX_W-1:0]     seq_index_o;
  logic [LEN_W-1:0]     token_offset_o;
  logic [SIZE_W-1:0]    piece_tokens_o;
  logic                 chunk_start_o;
  logic [1:0]           status_o;
  logic                 last_o;

  int unsigned fail_count;
  int unsigned pending_pieces;
  int unsigned pieces_checked;

  // knobs shared by the stimulus and the receiver
  bit          no_idle       = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned sent_count    = 0;
  int unsigned config_count  = 0;
  int unsigned idle_cycles   = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  token_chunk_planner i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .seq_length_i,
    .out_valid_o,
    .out_ready_i,
    .chunk_size_o,
    .seq_index_o,
    .token_offset_o,
    .piece_tokens_o,
    .chunk_start_o,
    .status_o,
    .last_o
  );

  chunk_plan_checker #(.CFG_IDX_W(CFG_IDX_W)) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .command_i,
    .seq_length_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .chunk_size_i   (chunk_size_o),
    .seq_index_i    (seq_index_o),
    .token_offset_i (token_offset_o),
    .piece_tokens_i (piece_tokens_o),
    .chunk_start_i  (chunk_start_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_pieces),
    .pieces_o       (pieces_checked)
  );

  // Draw the wait before the next request or piece; zero during burst stretches.
  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // Offer one request and hold it until the planner takes it. Valid is only
  // lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(command_e cmd, int unsigned len);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    seq_length_i <= LEN_W'(len);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Drop valid, wait for every expected piece, then let a resultless request finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pieces != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers on consecutive cycles; the enable stays high between them.
  task automatic set_config(int unsigned va, int unsigned vb, int unsigned vc,
                            int unsigned vd, int unsigned lim);
    logic [SIZE_W-1:0] regs [NUM_VARIANTS_DEF + 1];
    regs[0] = SIZE_W'(va);
    regs[1] = SIZE_W'(vb);
    regs[2] = SIZE_W'(vc);
    regs[3] = SIZE_W'(vd);
    // batch limit follows the variant sizes
    regs[NUM_VARIANTS_DEF] = SIZE_W'(lim);
    for (int i = 0; i <= NUM_VARIANTS_DEF; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= regs[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  // Pick a variant table: mostly with a one-token size somewhere in it,
  // sometimes without, with zeros, duplicates and the 4096 extreme mixed in.
  task automatic random_config();
    int unsigned v [NUM_VARIANTS_DEF];
    for (int i = 0; i < NUM_VARIANTS_DEF; i++) begin
      case ($urandom_range(0, 5))
        0:       v[i] = 0;
        1:       v[i] = $urandom_range(2, 16);
        2:       v[i] = $urandom_range(17, 256);
        3:       v[i] = $urandom_range(257, 4096);
        4:       v[i] = 1 << $urandom_range(1, 12);
        default: v[i] = (i > 0) ? v[i-1] : 4096;
      endcase
    end
    if ($urandom_range(0, 9) != 0) v[$urandom_range(0, NUM_VARIANTS_DEF - 1)] = ONE_TOKEN;
    set_config(v[0], v[1], v[2], v[3], $urandom_range(0, 63));
  endtask

  // Mostly single tokens and short runs; long subsequences stay rare to bound runtime.
  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       send_request(CMD_END, $urandom_range(0, 4095));
    else if (pick < 10) send_request(CMD_NEXT, 0);
    else if (pick < 50) send_request(CMD_NEXT, 1);
    else if (pick < 80) send_request(CMD_NEXT, $urandom_range(2, 64));
    else if (pick < 95) send_request(CMD_NEXT, $urandom_range(65, 600));
    else                send_request(CMD_NEXT, $urandom_range(601, 4095));
  endtask

  // Receiver: per piece, wait a random number of cycles with ready low. A hold
  // request from the stimulus turns the next wait into a long stretch so the
  // planner backs up and stalls its input.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    forever begin
      if (long_hold_req) begin
        gap = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Watchdog: end the run if no handshake or register write happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    command_i    = CMD_NEXT;
    seq_length_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset table holds only the one-token size: zero length, batching with
    // limit one, a two-token cut and a 4095-token run that overflows the cap.
    send_request(CMD_NEXT, 0);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 2);
    send_request(CMD_NEXT, 4095);
    send_request(CMD_END, 4095);
    settle();

    // No variant at all, then a table whose smallest size is not one.
    set_config(0, 0, 0, 0, 5);
    send_request(CMD_NEXT, 7);
    send_request(CMD_END, 0);
    settle();
    set_config(8, 16, 0, 8, 3);
    send_request(CMD_NEXT, 1);
    settle();

    // Unsorted table with the 4096 extreme; limit above the batch depth.
    // Exercise padding to the smallest multi-token size, padding within four
    // times the tokens, a fallback to a smaller size and an end flush.
    set_config(4096, 1, 64, 16, 63);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 4095);
    send_request(CMD_NEXT, 3);
    send_request(CMD_NEXT, 17);
    send_request(CMD_NEXT, 100);
    send_request(CMD_END, 0);
    settle();

    // Duplicate sizes and a zero limit; largest size four forces overflow.
    set_config(1, 1, 4, 0, 0);
    send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 4095);
    settle();

    // Grow a batch, then shrink the largest size below it before flushing.
    set_config(1, 64, 0, 0, 8);
    repeat (4) send_request(CMD_NEXT, 1);
    settle();
    set_config(1, 2, 0, 0, 8);
    send_request(CMD_NEXT, 1);
    send_request(CMD_END, 0);
    settle();

    // Random phases, each under a fresh table. One phase starts with the long
    // receiver hold-off while requests keep coming.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      no_idle = ($urandom_range(0, 3) == 0);
      if (ph == 2) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_request();
      settle();
    end
    no_idle = 1'b0;

    // Extremes last: full-size variants and the largest batch.
    set_config(1, 4096, 4096, 2, 32);
    repeat (40) send_request(CMD_NEXT, 1);
    send_request(CMD_NEXT, 4095);
    send_request(CMD_END, 0);
    settle();

    $display("Covered %0d requests under %0d register settings, %0d pieces compared",
             sent_count, config_count, pieces_checked);
    $display("Included one-token errors, chunk overflow, batch shrink and a %0d-cycle stall",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
